[rtl/fixed_byte_substring_detect_top_assert.svh]
// Assertion macros for the substring detector RTL.
`ifndef FIXED_BYTE_SUBSTRING_DETECT_TOP_ASSERT_SVH
`define FIXED_BYTE_SUBSTRING_DETECT_TOP_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define FBSD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("fbsd: invariant violated");

// The consequent must hold in the cycle after the antecedent.
`define FBSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fbsd: next-cycle check failed");

`endif

[rtl/fbsd_pkg.sv]
// Shared types and constants for the fixed byte substring detector.
package fbsd_pkg;

    localparam int MAX_PATTERN = 32;

    typedef enum logic [1:0] {
        KIND_PATTERN = 2'd0,
        KIND_TEXT    = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_MISSING = 2'd3
    } fbsd_kind_t;

    typedef enum logic [1:0] {
        VERDICT_NOT_FOUND = 2'd0,
        VERDICT_FOUND     = 2'd1,
        VERDICT_MISSING   = 2'd2,
        VERDICT_TOO_LONG  = 2'd3
    } fbsd_verdict_t;

    // Per-cycle control broadcast to every cell of the chain.
    typedef struct packed {
        logic pat_shift;
        logic txt_shift;
        logic clear;
    } fbsd_ctl_t;

endpackage

[rtl/fbsd_cell.sv]
// One cell of the detector chain: a pattern byte, a text byte and their valid bits.
module fbsd_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  fbsd_pkg::fbsd_ctl_t ctl,
    input  logic [7:0]        pat_in,
    input  logic              pv_in,
    input  logic [7:0]        txt_in,
    input  logic              wv_in,
    output logic [7:0]        pat_out,
    output logic              pv_out,
    output logic [7:0]        txt_out,
    output logic              wv_out,
    output logic              hit
);
    import fbsd_pkg::*;

    logic [7:0] pat_reg;
    logic [7:0] txt_reg;
    logic       pv_reg;
    logic       wv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
            wv_reg <= 1'b0;
        end else if (ctl.clear) begin
            pv_reg <= 1'b0;
            wv_reg <= 1'b0;
        end else begin
            if (ctl.pat_shift) begin
                pv_reg <= pv_in;
            end
            if (ctl.txt_shift) begin
                wv_reg <= wv_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.pat_shift) begin
            pat_reg <= pat_in;
        end
        if (ctl.txt_shift) begin
            txt_reg <= txt_in;
        end
    end

    // Compare against the byte that shifts in this cycle, so the result
    // reflects the window after the shift.
    assign hit     = !pv_reg || (wv_in && (pat_reg == txt_in));
    assign pat_out = pat_reg;
    assign pv_out  = pv_reg;
    assign txt_out = txt_reg;
    assign wv_out  = wv_reg;

endmodule

[rtl/fixed_byte_substring_detect_top.sv]
// Top level of the fixed byte substring detector.
//
//  Channel  Direction  Signals                     Contents
//  s_       in         tvalid tready tdata tuser   tdata: data; tuser: kind; tlast: last
//            tlast
//  m_       out        tvalid tready tdata         tdata: verdict, zero-filled to a byte
//
// The block accepts one word per cycle while s_tready is high; the window compare
// over all cells completes in the cycle the byte is accepted, so there is no iteration.
// A verdict is written to the output register at the edge that accepts the
// record-ending word and is offered on m_tvalid from the next cycle on.
// A new word is still taken while that verdict waits, as long as m_tready is high.
// Reset is synchronous and active low and empties the pattern and the window.
// If the output register is full and m_tready is low, s_tready drops.
`include "fixed_byte_substring_detect_top_assert.svh"

module fixed_byte_substring_detect_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data
    input  logic [1:0] s_tuser,   // [1:0] kind
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] verdict, [7:2] zero
);
    import fbsd_pkg::*;

    // Chain signals; element i is the output of cell i, and cell i takes
    // the output of cell i-1 (cell 0 takes the input word).
    logic [7:0]             pat_chain [MAX_PATTERN];
    logic [7:0]             txt_chain [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pv;
    logic [MAX_PATTERN-1:0] wv;
    logic [MAX_PATTERN-1:0] hit;

    fbsd_ctl_t     ctl;
    fbsd_kind_t    kind;
    fbsd_verdict_t verdict;

    logic          accept;
    logic          pat_ok;
    logic          full;
    logic          end_item;
    logic          match;
    logic          found_next;

    logic          done_reg;
    logic          overflow_reg;
    logic          found_reg;
    logic          m_tvalid_reg;
    fbsd_verdict_t verdict_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign kind     = fbsd_kind_t'(s_tuser);

    // The pattern is full once the valid bit reaches the final cell.
    assign full   = pv[MAX_PATTERN-1];
    // Pattern words after the end of the pattern are dropped silently.
    assign pat_ok = accept && (kind == KIND_PATTERN) && !done_reg;

    assign ctl.pat_shift = pat_ok && !full;
    assign ctl.txt_shift = accept && (kind == KIND_TEXT);
    assign end_item      = accept && (((kind == KIND_TEXT) && s_tlast)
                                      || (kind == KIND_EMPTY)
                                      || (kind == KIND_MISSING));
    assign ctl.clear     = end_item;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                fbsd_cell u_cell (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .ctl     (ctl),
                    .pat_in  (s_tdata),
                    .pv_in   (1'b1),
                    .txt_in  (s_tdata),
                    .wv_in   (1'b1),
                    .pat_out (pat_chain[gi]),
                    .pv_out  (pv[gi]),
                    .txt_out (txt_chain[gi]),
                    .wv_out  (wv[gi]),
                    .hit     (hit[gi])
                );
            end else begin : g_body
                fbsd_cell u_cell (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .ctl     (ctl),
                    .pat_in  (pat_chain[gi-1]),
                    .pv_in   (pv[gi-1]),
                    .txt_in  (txt_chain[gi-1]),
                    .wv_in   (wv[gi-1]),
                    .pat_out (pat_chain[gi]),
                    .pv_out  (pv[gi]),
                    .txt_out (txt_chain[gi]),
                    .wv_out  (wv[gi]),
                    .hit     (hit[gi])
                );
            end
        end
    endgenerate

    // Cells hold the pattern newest-first, exactly aligned with the text
    // window, so a match is every loaded cell agreeing with its text byte.
    // A cell whose text byte is not yet valid fails, which covers texts
    // shorter than the pattern.
    assign match      = pv[0] && !overflow_reg && (&hit);
    assign found_next = found_reg || (ctl.txt_shift && match);

    always_comb begin
        if (kind == KIND_MISSING) begin
            verdict = VERDICT_MISSING;
        end else if (overflow_reg) begin
            verdict = VERDICT_TOO_LONG;
        end else if (!pv[0]) begin
            verdict = VERDICT_MISSING;
        end else if (found_next) begin
            verdict = VERDICT_FOUND;
        end else begin
            verdict = VERDICT_NOT_FOUND;
        end
    end

    // Record state. A record-ending word clears everything for the next one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg     <= 1'b0;
            overflow_reg <= 1'b0;
            found_reg    <= 1'b0;
        end else if (ctl.clear) begin
            done_reg     <= 1'b0;
            overflow_reg <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            // A text byte also ends pattern loading, even without tlast.
            if ((pat_ok && s_tlast) || ctl.txt_shift) begin
                done_reg <= 1'b1;
            end
            if (pat_ok && full) begin
                overflow_reg <= 1'b1;
            end
            found_reg <= found_next;
        end
    end

    // Output register: holds one verdict until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (end_item) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (end_item) begin
            verdict_reg <= verdict;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b000000, verdict_reg};

    // The loaded pattern and the valid text always form a prefix of the chain.
    `FBSD_ASSERT_ALWAYS(a_pv_prefix, pv[0] || (pv == '0))
    `FBSD_ASSERT_ALWAYS(a_wv_prefix, wv[0] || (wv == '0))
    // Overflow only happens with a full pattern store.
    `FBSD_ASSERT_ALWAYS(a_ovf_full, !overflow_reg || full)
    // A match cannot be recorded without a loaded pattern.
    `FBSD_ASSERT_ALWAYS(a_found_pat, !found_reg || pv[0])
    // A record-ending word leaves a clean record state and a pending verdict.
    `FBSD_ASSERT_NEXT(a_end_clear, end_item,
        (pv == '0) && (wv == '0) && !done_reg && !overflow_reg && !found_reg && m_tvalid_reg)

endmodule

[dv/testbench.sv]
// Self-checking testbench for the fixed byte substring detector top level.
`timescale 1ns / 100ps

module testbench;
    import fbsd_pkg::*;

    // Run length and safety limit. The limit covers every word waiting out
    // random source gaps and sink stalls several times over.
    localparam int WORD_TARGET = 1350;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    // One row of the directed table. A row is sent reps times in a row.
    // Where known is set, the verdict is typed in here rather than taken
    // from the predictor.
    typedef struct packed {
        fbsd_kind_t    kind;
        logic [7:0]    data;
        logic          last;
        logic [5:0]    reps;
        logic          known;
        fbsd_verdict_t verdict;
    } stim_row_t;

    // Per-word note that travels alongside each input word, so that the
    // monitor knows whether a typed-in verdict overrides the predictor.
    typedef struct packed {
        logic          known;
        fbsd_verdict_t verdict;
    } pinned_t;

    localparam int DIRECTED_ROWS = 26;

    // Directed table: the empty and missing cases, byte extremes, a text
    // shorter than its pattern, text that ends pattern loading, a pattern
    // byte arriving after the pattern is closed, and two overflowed patterns.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{KIND_MISSING, 8'hA5, 1'b1, 6'd1,  1'b1, VERDICT_MISSING},
        '{KIND_EMPTY,   8'h3C, 1'b0, 6'd1,  1'b1, VERDICT_MISSING},
        '{KIND_PATTERN, 8'h00, 1'b1, 6'd1,  1'b0, VERDICT_NOT_FOUND},
        '{KIND_TEXT,    8'h00, 1'b1, 6'd1,  1'b1, VERDICT_FOUND},
        '{KIND_PATTERN, 8'hFF, 1'b1, 6'd1,  1'b0, VERDICT_NOT_FOUND},
        '{KIND_TEXT,    8'h00, 1'b0, 6'd1,  1'b0, VERDICT_NOT_FOUND},
        '{KIND_TEXT,    8'hFF, 1'b1, 6'd1,  1'b1, VERDICT_FOUND},
        '{KIND_PATTERN, 8'h61, 1'b0, 6'd1,  1'b0, VERDICT_NOT_FOUND},
        '{KIND_PATTERN, 8'h62, 1'b1, 6'd1,  1'b0, VERDICT_NOT_FOUND},
        '{KIND_TEXT,    8'h61, 1'b1, 6'd1,  1'b1, VERDICT_NOT_FOUND},
        '{KIND_PATTERN, 8'h5A, 1'b1, 6'd1,  1'b0, VERDICT_NOT_FOUND},
        '{KIND_EMPTY,   8'h00, 1'b1, 6'd1,  1'b1, VERDICT_NOT_FOUND},
        '{KIND_PATTERN, 8'h12, 1'b0, 6'd1,  1'b0, VERDICT_NOT_FOUND},
        '{KIND_TEXT,    8'h12, 1'b1, 6'd1,  1'b1, VERDICT_FOUND},
        '{KIND_PATTERN, 8'h77, 1'b1, 6'd1,  1'b0, VERDICT_NOT_FOUND},
        '{KIND_PATTERN, 8'h12, 1'b1, 6'd1,  1'b0, VERDICT_NOT_FOUND},
        '{KIND_TEXT,    8'h12, 1'b0, 6'd1,  1'b0, VERDICT_NOT_FOUND},
        '{KIND_TEXT,    8'h77, 1'b1, 6'd1,  1'b0, VERDICT_NOT_FOUND},
        '{KIND_PATTERN, 8'h33, 1'b1, 6'd1,  1'b0, VERDICT_NOT_FOUND},
        '{KIND_MISSING, 8'h33, 1'b0, 6'd1,  1'b1, VERDICT_MISSING},
        '{KIND_TEXT,    8'h41, 1'b1, 6'd1,  1'b1, VERDICT_MISSING},
        '{KIND_PATTERN, 8'h80, 1'b0, 6'd33, 1'b0, VERDICT_NOT_FOUND},
        '{KIND_PATTERN, 8'h81, 1'b1, 6'd1,  1'b0, VERDICT_NOT_FOUND},
        '{KIND_TEXT,    8'h80, 1'b1, 6'd1,  1'b1, VERDICT_TOO_LONG},
        '{KIND_PATTERN, 8'hC3, 1'b0, 6'd33, 1'b0, VERDICT_NOT_FOUND},
        '{KIND_EMPTY,   8'h7E, 1'b1, 6'd1,  1'b1, VERDICT_TOO_LONG}
    };

    // Clock, reset and the block's ports; the driven inputs are known from time zero.
    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data
    logic [1:0] s_tuser  = KIND_PATTERN;   // [1:0] kind
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [1:0] verdict, [7:2] zero

    // Predictor state: the loaded pattern, the window of newest text bytes
    // (entry 0 newest), and the record flags.
    logic [7:0] needle_bytes [MAX_PATTERN];
    int         needle_len = 0;
    bit         needle_overflow = 1'b0;
    bit         needle_closed = 1'b0;
    logic [7:0] text_recent [MAX_PATTERN];
    int         text_seen = 0;
    bit         hit_seen = 1'b0;

    fbsd_verdict_t verdict_q [$];   // verdicts still owed by the block
    pinned_t       pinned_q [$];    // one note per word offered, in order

    int  words_sent = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  gaps_on = 1'b1;

    fixed_byte_substring_detect_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Advances the predictor by one accepted word. Returns 1 when the word
    // ends a record, with the verdict that the block must then produce.
    function automatic bit detect_step(input fbsd_kind_t kind, input logic [7:0] data,
                                       input logic last, output fbsd_verdict_t verdict);
        bit ends_record;
        bit window_equal;
        ends_record = 1'b0;
        verdict = VERDICT_NOT_FOUND;
        case (kind)
            KIND_PATTERN: begin
                // Once the pattern is closed, further pattern words are dropped.
                if (!needle_closed) begin
                    if (needle_len < MAX_PATTERN) begin
                        needle_bytes[needle_len] = data;
                        needle_len++;
                    end else begin
                        needle_overflow = 1'b1;
                    end
                    if (last)
                        needle_closed = 1'b1;
                end
            end
            KIND_TEXT: begin
                // Any text byte closes the pattern, even without a last flag.
                needle_closed = 1'b1;
                for (int i = MAX_PATTERN - 1; i > 0; i--)
                    text_recent[i] = text_recent[i - 1];
                text_recent[0] = data;
                if (text_seen < MAX_PATTERN)
                    text_seen++;
                // The newest needle_len bytes, newest first, against the
                // pattern read backward.
                window_equal = needle_len > 0 && !needle_overflow && text_seen >= needle_len;
                for (int i = 0; i < needle_len; i++)
                    if (text_recent[i] != needle_bytes[needle_len - 1 - i])
                        window_equal = 1'b0;
                if (window_equal)
                    hit_seen = 1'b1;
                ends_record = last;
            end
            default: begin
                ends_record = 1'b1;
            end
        endcase
        if (ends_record) begin
            if (kind == KIND_MISSING)
                verdict = VERDICT_MISSING;
            else if (needle_overflow)
                verdict = VERDICT_TOO_LONG;
            else if (needle_len == 0)
                verdict = VERDICT_MISSING;
            else
                verdict = hit_seen ? VERDICT_FOUND : VERDICT_NOT_FOUND;
            needle_len = 0;
            needle_overflow = 1'b0;
            needle_closed = 1'b0;
            text_seen = 0;
            hit_seen = 1'b0;
            for (int i = 0; i < MAX_PATTERN; i++)
                text_recent[i] = 8'h00;
        end
        return ends_record;
    endfunction

    // Offers one word and holds it until the block takes it. Random source
    // gaps come first, while gaps are enabled.
    task automatic send_word(input fbsd_kind_t kind, input logic [7:0] data, input logic last,
                             input logic known, input fbsd_verdict_t verdict);
        while (gaps_on && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        pinned_q.push_back(pinned_t'{known, verdict});
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= kind;
        s_tlast  <= last;
        do
            @(posedge aclk);
        while (!s_tready);
        words_sent++;
    endtask

    // One random record. Most records are well formed, and half of all records
    // draw their random content from a narrow byte range so that matches are
    // common; a minority leave the pattern unclosed, add a dropped pattern byte,
    // end as missing, or overflow the pattern store.
    task automatic random_record();
        logic [7:0] needle [40];
        logic [7:0] base;
        logic [7:0] text_byte;
        int         pick;
        int         plen;
        int         tlen;
        int         spot;
        bit         wide;
        bit         close_needle;
        pick = $urandom_range(99);
        if (pick < 5)
            plen = 0;
        else if (pick < 75)
            plen = $urandom_range(4, 1);
        else if (pick < 88)
            plen = $urandom_range(12, 5);
        else if (pick < 94)
            plen = $urandom_range(32, 31);
        else
            plen = $urandom_range(36, 33);
        wide = ($urandom_range(1) == 0);
        base = 8'($urandom_range(255));
        close_needle = ($urandom_range(99) >= 8);
        for (int i = 0; i < plen; i++) begin
            needle[i] = wide ? 8'($urandom_range(255)) : base + 8'($urandom_range(2));
            send_word(KIND_PATTERN, needle[i], close_needle && i == plen - 1,
                      1'b0, VERDICT_NOT_FOUND);
        end
        if (close_needle && plen > 0 && $urandom_range(99) < 5)
            send_word(KIND_PATTERN, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'b0, VERDICT_NOT_FOUND);
        if ($urandom_range(99) < 5) begin
            send_word(KIND_MISSING, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'b0, VERDICT_NOT_FOUND);
        end else begin
            pick = $urandom_range(99);
            if (pick < 12)
                tlen = 0;
            else if (pick < 90)
                tlen = $urandom_range(12, 1);
            else
                tlen = $urandom_range(40, 13);
            if (tlen == 0) begin
                send_word(KIND_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'b0, VERDICT_NOT_FOUND);
            end else begin
                // Plant the pattern somewhere in the text in a fair share of records.
                spot = -1;
                if (plen > 0 && plen <= tlen && $urandom_range(99) < 45)
                    spot = $urandom_range(tlen - plen);
                for (int i = 0; i < tlen; i++) begin
                    if (spot >= 0 && i >= spot && i < spot + plen)
                        text_byte = needle[i - spot];
                    else
                        text_byte = wide ? 8'($urandom_range(255))
                                         : base + 8'($urandom_range(2));
                    send_word(KIND_TEXT, text_byte, i == tlen - 1, 1'b0, VERDICT_NOT_FOUND);
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    // The sink stalls at random while gaps are enabled and is always ready
    // during the quiet stretch.
    always @(posedge aclk)
        m_tready <= gaps_on ? ($urandom_range(99) >= 23) : 1'b1;

    // Monitor: reads both channels as they stood at the clock edge. An
    // accepted input word advances the predictor; an accepted result word
    // is compared with the oldest verdict still owed.
    always @(posedge aclk) begin
        pinned_t       pin;
        fbsd_verdict_t predicted;
        fbsd_verdict_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pin = pinned_q.pop_front();
                if (detect_step(fbsd_kind_t'(s_tuser), s_tdata, s_tlast, predicted))
                    verdict_q.push_back(pin.known ? pin.verdict : predicted);
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected verdict word, data", -1, m_tdata);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[1:0] !== want)
                        report_mismatch("verdict", want, m_tdata[1:0]);
                    if (m_tdata[7:2] !== 6'd0)
                        report_mismatch("zero fill", 0, m_tdata[7:2]);
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        // Synchronous reset, asserted from time zero and released once.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table.
        for (int r = 0; r < DIRECTED_ROWS; r++)
            for (int n = 0; n < directed_rows[r].reps; n++)
                send_word(directed_rows[r].kind, directed_rows[r].data, directed_rows[r].last,
                          directed_rows[r].known, directed_rows[r].verdict);

        // Random records, with stray words of any kind mixed in. A stretch
        // in the middle runs with neither side idling.
        while (words_sent < WORD_TARGET) begin
            gaps_on = !(words_sent >= 500 && words_sent < 800);
            if ($urandom_range(99) < 4)
                send_word(fbsd_kind_t'($urandom_range(3)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'b0, VERDICT_NOT_FOUND);
            random_record();
        end
        s_tvalid <= 1'b0;
        // Let the monitor record the final accepted word before counting
        // what is still owed.
        @(posedge aclk);

        // Drain the owed verdicts, then let the block settle so that a stray
        // extra word would still be caught.
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && verdict_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/fbsd_pkg.sv
rtl/fbsd_cell.sv
rtl/fixed_byte_substring_detect_top.sv
dv/testbench.sv
